### rtl/core/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg - shared types and constants
// Field widths, commands, product modes and the controller/datapath signals.
// ----------------------------------------------------------------------------
package smv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
    localparam int POS_W        = 10;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        CMD_WRITE_VECTOR = 2'd0,
        CMD_WRITE_RESULT = 2'd1,
        CMD_ENTRY        = 2'd2,
        CMD_READ_RESULT  = 2'd3
    } t_cmd;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_SYM   = 2'd2;
    localparam logic [1:0] MODE_OFF   = 2'd3;

    localparam logic [0:0] CFG_MODE  = 1'b0;
    localparam logic [0:0] CFG_SCALE = 1'b1;
    localparam logic [DATA_W-1:0] SCALE_RESET = 32'sd65536;

    typedef struct packed {
        logic [1:0]        command;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]  result_index;
        logic [DATA_W-1:0] result_value;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture input item
        logic rd;      // issue store reads for one update
        logic swap;    // 0: target row/source column, 1: target column/source row
        logic mul1;    // capture first product
        logic mul2;    // capture second product
        logic wr;      // write back result
        logic rdout;   // issue result read for readback
        logic outld;   // capture output register
    } t_cmd_bus;

    function automatic logic [DATA_W-1:0] sat_shift(input logic signed [63:0] p);
        logic signed [47:0] s;
        s = 48'(p >>> 16);
        if (s > 48'sh7FFFFFFF)       sat_shift = 32'h7FFFFFFF;
        else if (s < -48'sh80000000) sat_shift = 32'h80000000;
        else                          sat_shift = s[31:0];
    endfunction

endpackage

### rtl/core/smv_ram.sv
// ----------------------------------------------------------------------------
// smv_ram - generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module smv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/smv_datapath.sv
// ----------------------------------------------------------------------------
// smv_datapath - stores and multiply-accumulate datapath
// Holds the vector and result RAMs, two registered Q16.16 multiplies and
// the saturating accumulate.
// ----------------------------------------------------------------------------
module smv_datapath import smv_pkg::*; (
    input  logic        i_clk,
    input  t_in         i_item,
    input  t_cmd_bus    i_ctl,
    input  logic [DATA_W-1:0] i_scale,
    output logic        o_same_pos,
    output t_out        o_out
);
    t_in               r_item;
    logic [DATA_W-1:0] r_t, r_d;
    logic              r_skip;
    logic [ADDR_W-1:0] r_tgt;
    logic [POS_W-1:0]  tgt_pos, src_pos;
    logic              oob;
    logic [DATA_W-1:0] v_rd, res_rd;
    logic [ADDR_W-1:0] v_addr, res_addr;
    logic              v_we, res_we;
    logic [DATA_W-1:0] res_wdata, sum_sat;
    logic signed [32:0] sum;

    assign o_same_pos = (r_item.row == r_item.column);

    always_comb begin
        tgt_pos = i_ctl.swap ? r_item.column : r_item.row;
        src_pos = i_ctl.swap ? r_item.row : r_item.column;
        oob = (32'(tgt_pos) >= VECTOR_DEPTH) || (32'(src_pos) >= VECTOR_DEPTH);
        v_we = i_ctl.load && (i_item.command == CMD_WRITE_VECTOR)
               && (32'(i_item.row) < VECTOR_DEPTH);
        v_addr = i_ctl.load ? ADDR_W'(i_item.row) : ADDR_W'(src_pos);
        sum = 33'($signed(res_rd)) + 33'($signed(r_d));
        if (sum > 33'sh7FFFFFFF)       sum_sat = 32'h7FFFFFFF;
        else if (sum < -33'sh80000000) sum_sat = 32'h80000000;
        else                           sum_sat = sum[31:0];
        res_we = (i_ctl.load && (i_item.command == CMD_WRITE_RESULT)
                  && (32'(i_item.row) < VECTOR_DEPTH))
                 || (i_ctl.wr && !r_skip);
        res_wdata = i_ctl.load ? i_item.value : sum_sat;
        if (i_ctl.load)       res_addr = ADDR_W'(i_item.row);
        else if (i_ctl.rdout) res_addr = ADDR_W'(r_item.row);
        else if (i_ctl.rd)    res_addr = ADDR_W'(tgt_pos);
        else                  res_addr = r_tgt;
    end

    smv_ram #(.WIDTH(DATA_W), .DEPTH(VECTOR_DEPTH)) u_vec (
        .i_clk(i_clk), .i_we(v_we), .i_addr(v_addr),
        .i_wdata(i_item.value), .o_rdata(v_rd));

    smv_ram #(.WIDTH(DATA_W), .DEPTH(VECTOR_DEPTH)) u_res (
        .i_clk(i_clk), .i_we(res_we), .i_addr(res_addr),
        .i_wdata(res_wdata), .o_rdata(res_rd));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        if (i_ctl.rd) begin
            r_tgt  <= ADDR_W'(tgt_pos);
            r_skip <= oob;
        end
        if (i_ctl.mul1) begin
            r_t    <= sat_shift(64'($signed(r_item.value)) * 64'($signed(v_rd)));
            r_skip <= r_skip || (v_rd == '0);
        end
        if (i_ctl.mul2) begin
            r_d <= sat_shift(64'($signed(r_t)) * 64'($signed(i_scale)));
        end
        if (i_ctl.outld) begin
            o_out.result_index <= r_item.row;
            o_out.result_value <= (32'(r_item.row) < VECTOR_DEPTH) ? res_rd : '0;
        end
    end
endmodule

### rtl/core/smv_ctrl.sv
// ----------------------------------------------------------------------------
// smv_ctrl - command sequencer
// Decodes each item and steps the datapath through reads, two multiplies
// and the write-back, once or twice per matrix entry.
// ----------------------------------------------------------------------------
module smv_ctrl import smv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_item,
    input  logic [1:0] i_mode,
    input  logic       i_same_pos,
    input  logic       i_out_stall,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd_bus   o_ctl
);
    typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL1, S_MUL2, S_WR, S_OUTRD, S_OUTLD}
        t_state;
    t_state r_state;
    logic   r_swap, r_second, r_out_valid;
    logic   accept, sym_more;
    t_cmd   cmd;

    assign cmd        = t_cmd'(i_item.command);
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctl       = '0;
        o_ctl.load  = accept;
        o_ctl.swap  = r_swap;
        o_ctl.rd    = (r_state == S_RD);
        o_ctl.mul1  = (r_state == S_MUL1);
        o_ctl.mul2  = (r_state == S_MUL2);
        o_ctl.wr    = (r_state == S_WR);
        o_ctl.rdout = (r_state == S_OUTRD);
        o_ctl.outld = (r_state == S_OUTLD);
    end

    // mirrored update only off the diagonal
    assign sym_more = !r_second && (i_mode == MODE_SYM) && !i_same_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_swap      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_second <= 1'b0;
                        r_swap   <= (i_mode == MODE_TRANS);
                        if (cmd == CMD_ENTRY && i_mode != MODE_OFF) begin
                            r_state <= S_RD;
                        end else if (cmd == CMD_READ_RESULT) begin
                            r_state <= S_OUTRD;
                        end
                    end
                end
                S_RD:   r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_WR;
                S_WR: begin
                    if (sym_more) begin
                        r_second <= 1'b1;
                        r_swap   <= 1'b1;
                        r_state  <= S_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUTRD: r_state <= S_OUTLD;
                S_OUTLD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/sparse_matrix_vector_mac.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_mac - sparse matrix-vector multiply-accumulate
// Vector and result element writes complete with the transfer; a read holds
// the input through the result RAM read and the output register load that
// raises its result; a matrix entry steps through the transfer, store read,
// two registered multiplies and write-back, repeating read to write-back in
// symmetric mode when row and column differ. A pending result stalls the
// input while the output is stalled. The stores are not cleared at reset.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_mac import smv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);
    logic [1:0]        r_mode;
    logic [DATA_W-1:0] r_scale;
    t_cmd_bus          ctl;
    logic              same_pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_SCALE: r_scale <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    smv_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_item(i_in_data), .i_mode(r_mode), .i_same_pos(same_pos),
        .i_out_stall(i_out_stall),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid), .o_ctl(ctl));

    smv_datapath u_dp (
        .i_clk(i_clk), .i_item(i_in_data), .i_ctl(ctl),
        .i_scale(r_scale), .o_same_pos(same_pos), .o_out(o_out_data));

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.rd || ctl.wr) |-> o_in_stall) else $error("accept while busy");
    a_out_after_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.outld |=> o_out_valid) else $error("output not raised");
`endif
endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - regression bench for sparse_matrix_vector_mac
// Drives vector/result writes, matrix entries and readbacks through the
// valid/stall input channel, predicts readbacks from the directed table or
// an in-bench Q16.16 model of the stores, and checks each result transfer in
// order. Runs a directed table, then random traffic under every product mode,
// several scale factors, varying idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import smv_pkg::*;

    localparam int N_PHASES   = 7;
    localparam int PHASE_ITEMS = 236;
    localparam int DRAIN_CYC  = 24;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        t_in         item;
        bit          typed;
        logic [31:0] exp_v;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    t_in               in_data = '0;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    t_out              o_out_data;
    logic              cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [0:0]        cfg_index = CFG_MODE;
    logic [DATA_W-1:0] cfg_data = '0;

    sparse_matrix_vector_mac dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // bench copy of the block state
    logic signed [31:0] vec_mem [VECTOR_DEPTH];
    logic signed [31:0] res_mem [VECTOR_DEPTH];
    bit                 vec_set [VECTOR_DEPTH];
    bit                 res_set [VECTOR_DEPTH];
    int                 live_pos[$];
    logic [1:0]         mode_q = MODE_PLAIN;
    logic signed [31:0] scale_q = SCALE_RESET;

    t_out    readback_q[$];
    t_dir_row dir_tab[$];
    int      err_cnt = 0;
    int      cyc = 0;
    int      in_idle_pct = 18;
    int      out_idle_pct = 70;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;
    int      hold_left = 0;
    int      sent = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] exp_v);
        $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, exp_v, cyc);
        err_cnt++;
    endtask

    function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
        if (x > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (x < -64'sh80000000) return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic void mac_update(int tgt, int src, logic signed [31:0] m);
        logic signed [31:0] v, t, d;
        v = vec_mem[src];
        if (v == 0) return;
        t = clamp32((64'(m) * 64'(v)) >>> 16);
        d = clamp32((64'(t) * 64'(scale_q)) >>> 16);
        res_mem[tgt] = clamp32(64'(res_mem[tgt]) + 64'(d));
    endfunction

    function automatic void mark_set(int p, bit is_vec);
        bit was;
        was = vec_set[p] && res_set[p];
        if (is_vec) vec_set[p] = 1'b1;
        else res_set[p] = 1'b1;
        if (!was && vec_set[p] && res_set[p]) live_pos.insert(live_pos.size(), p);
    endfunction

    // apply one accepted transfer, queue the readback it causes
    function automatic void smv_predict(t_in it, bit typed, logic [31:0] exp_v);
        t_out r;
        int rw, cl;
        rw = int'(it.row);
        cl = int'(it.column);
        case (t_cmd'(it.command))
            CMD_WRITE_VECTOR: begin
                vec_mem[rw] = it.value;
                mark_set(rw, 1'b1);
            end
            CMD_WRITE_RESULT: begin
                res_mem[rw] = it.value;
                mark_set(rw, 1'b0);
            end
            CMD_ENTRY: begin
                if (mode_q == MODE_PLAIN) begin
                    mac_update(rw, cl, it.value);
                end else if (mode_q == MODE_TRANS) begin
                    mac_update(cl, rw, it.value);
                end else if (mode_q == MODE_SYM) begin
                    mac_update(rw, cl, it.value);
                    if (rw != cl) mac_update(cl, rw, it.value);
                end
            end
            default: begin
                r.result_index = it.row;
                r.result_value = typed ? exp_v : res_mem[rw];
                readback_q.insert(readback_q.size(), r);
            end
        endcase
    endfunction

    task automatic send(t_in it, bit typed = 1'b0, logic [31:0] exp_v = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        smv_predict(it, typed, exp_v);
        sent++;
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MODE) mode_q = val[1:0];
        else scale_q = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (readback_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic dir(t_cmd c, int rw, int cl, logic [31:0] v,
                       bit typed = 1'b0, logic [31:0] exp_v = '0);
        t_dir_row d;
        d.item.command = c;
        d.item.row     = rw[POS_W-1:0];
        d.item.column  = cl[POS_W-1:0];
        d.item.value   = v;
        d.typed        = typed;
        d.exp_v        = exp_v;
        dir_tab.insert(dir_tab.size(), d);
    endtask

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) return 32'h7FFFFFFF;
        if (sel < 12) return 32'h80000000;
        if (sel < 16) return 32'h0;
        if (sel < 20) return 32'hFFFFFFFF;
        if (sel < 60) return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        return $urandom;
    endfunction

    function automatic t_in pick_item();
        t_in it;
        int sel;
        sel = $urandom_range(99);
        it.column = POS_W'(live_pos[$urandom_range(live_pos.size() - 1)]);
        it.row    = POS_W'(live_pos[$urandom_range(live_pos.size() - 1)]);
        it.value  = pick_value();
        if (sel < 14) begin
            it.command = CMD_WRITE_VECTOR;
            if ($urandom_range(3) == 0) it.row = POS_W'($urandom);
        end else if (sel < 24) begin
            it.command = CMD_WRITE_RESULT;
            if ($urandom_range(3) == 0) it.row = POS_W'($urandom);
        end else if (sel < 78) begin
            it.command = CMD_ENTRY;
        end else begin
            it.command = CMD_READ_RESULT;
        end
        return it;
    endfunction

    // output side: random stall plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (readback_q.size() == 0) begin
                report("unexpected result", o_out_data.result_value, '0);
            end else begin
                e = readback_q.pop_front();
                if (o_out_data.result_index !== e.result_index)
                    report("result_index", 32'(o_out_data.result_index),
                           32'(e.result_index));
                if (o_out_data.result_value !== e.result_value)
                    report("result_value", o_out_data.result_value, e.result_value);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout");
            $display("sparse_matrix_vector_mac regression: fail");
            $finish;
        end
    end

    initial begin
        logic [1:0]  ph_mode  [N_PHASES];
        logic [31:0] ph_scale [N_PHASES];
        t_in it;
        int p;

        ph_mode  = '{MODE_PLAIN, MODE_TRANS, MODE_SYM, MODE_OFF, MODE_SYM, MODE_TRANS,
                     MODE_PLAIN};
        ph_scale = '{SCALE_RESET, $urandom, 32'h7FFFFFFF, 32'h00020000, 32'h80000000,
                     32'hFFFF0000, 32'h0};
        for (int k = 0; k < VECTOR_DEPTH; k++) begin
            vec_set[k] = 1'b0;
            res_set[k] = 1'b0;
            vec_mem[k] = '0;
            res_mem[k] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: plain mode, scale 1.0
        dir(CMD_WRITE_VECTOR, 0, 0, 32'h00010000);
        dir(CMD_WRITE_VECTOR, 1023, 0, 32'hFFFF0000);
        dir(CMD_WRITE_RESULT, 0, 0, 32'h0);
        dir(CMD_WRITE_RESULT, 1023, 0, 32'h7FFFFFFF);
        dir(CMD_READ_RESULT, 1023, 0, 32'h0, 1'b1, 32'h7FFFFFFF);
        dir(CMD_ENTRY, 1023, 0, 32'h00010000);
        dir(CMD_READ_RESULT, 1023, 0, 32'h0, 1'b1, 32'h7FFFFFFF);
        dir(CMD_ENTRY, 0, 1023, 32'h7FFFFFFF);
        dir(CMD_READ_RESULT, 0, 0, 32'h0, 1'b1, 32'h80000001);
        dir(CMD_ENTRY, 0, 1023, 32'h80000000);
        dir(CMD_READ_RESULT, 0, 1023, 32'h0, 1'b1, 32'h0);
        dir(CMD_WRITE_VECTOR, 1, 0, 32'h0);
        dir(CMD_WRITE_RESULT, 1, 0, 32'h12345678);
        dir(CMD_ENTRY, 1, 1, 32'h7FFFFFFF);
        dir(CMD_READ_RESULT, 1, 0, 32'h0, 1'b1, 32'h12345678);
        dir(CMD_ENTRY, 0, 0, 32'h80000000);
        dir(CMD_ENTRY, 0, 0, 32'h80000000);
        dir(CMD_READ_RESULT, 0, 0, 32'h0, 1'b1, 32'h80000000);
        dir(CMD_ENTRY, 1023, 1, 32'h00010000);
        dir(CMD_READ_RESULT, 1023, 0, 32'hFFFFFFFF);
        foreach (dir_tab[k]) send(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].exp_v);

        // working set of positions with both stores written
        for (int k = 0; k < 40; k++) begin
            p = $urandom_range(VECTOR_DEPTH - 1);
            it.row = POS_W'(p);
            it.column = POS_W'($urandom);
            it.command = CMD_WRITE_VECTOR;
            it.value = pick_value();
            send(it);
            it.command = CMD_WRITE_RESULT;
            it.value = pick_value();
            send(it);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                cfg_write(CFG_MODE, 32'(ph_mode[ph]));
                cfg_write(CFG_SCALE, ph_scale[ph]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (sent < 600) begin
                    in_idle_pct  = 18;
                    out_idle_pct = 70;
                end else if (sent < 1200) begin
                    in_idle_pct  = 70;
                    out_idle_pct = 18;
                end else begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                    if (sent > 1450) hold_req = 1'b1;
                end
                send(pick_item());
            end
        end

        drain();
        if (err_cnt == 0) begin
            $display("sparse_matrix_vector_mac regression: pass");
        end else begin
            $display("sparse_matrix_vector_mac regression: fail");
        end
        $finish;
    end

endmodule
